>>> sv/stick_tip_hit_detector_core_assert.svh
// Assertion macros shared by the checker.
`ifndef STICK_TIP_HIT_DETECTOR_CORE_ASSERT_SVH
`define STICK_TIP_HIT_DETECTOR_CORE_ASSERT_SVH
`define STHD_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define STHD_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> sv/sthd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sthd_pkg;
  localparam int DRUM_COUNT_DEF = 8;
  localparam int CW = 16;
  localparam int VW = 24;
  localparam logic signed [31:0] NO_HIT_STEP = -32'sd1000000000;
  localparam logic [2:0] REG_ALPHA = 3'd0;
  localparam logic [2:0] REG_RADIUS = 3'd1;
  localparam logic [2:0] REG_ZWIN = 3'd2;
  localparam logic [2:0] REG_REARM = 3'd3;
  localparam logic [2:0] REG_MINSPD = 3'd4;

  typedef struct packed {
    logic [16:0] alpha;
    logic [14:0] radius;
    logic [14:0] zwin;
    logic [14:0] rearm;
    logic [22:0] minspd;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic signed [36:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [VW-1:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

>>> sv/stick_tip_hit_detector_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Stick tip hit detector. One transfer on the input channel gives one transfer
// on the output channel. A tip sample skips the velocity filter on the first
// sample or a zero time step; when the filter runs, each arm uses the 37-step
// serial divider and then two multiply-accumulate passes. Each arm then walks
// the drums one per cycle through a shared distance unit. The block takes no
// new item until the result has been accepted.
module stick_tip_hit_detector_core #(
  parameter int DRUM_COUNT = sthd_pkg::DRUM_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [4:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic op,
  input  wire logic [2:0] drum_sel,
  input  wire logic signed [15:0] left_x,
  input  wire logic signed [15:0] left_y,
  input  wire logic signed [15:0] left_z,
  input  wire logic signed [15:0] right_x,
  input  wire logic signed [15:0] right_y,
  input  wire logic signed [15:0] right_z,
  input  wire logic [15:0] delta_us,
  input  wire logic [30:0] step_now,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [7:0] armed_left,
  output logic [7:0] armed_right,
  output logic touch_left,
  output logic [2:0] touch_left_drum,
  output logic touch_right,
  output logic [2:0] touch_right_drum,
  output logic hit_left,
  output logic hit_right,
  output logic signed [31:0] last_hit_left,
  output logic signed [31:0] last_hit_right,
  output logic signed [23:0] vel_z_left,
  output logic signed [23:0] vel_z_right
);
  import sthd_pkg::*;
  localparam int DW = (DRUM_COUNT > 1) ? $clog2(DRUM_COUNT) : 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_DIV = 7'b0000010, S_MUL = 7'b0000100,
    S_ACC = 7'b0001000, S_SCAN = 7'b0010000, S_FIN = 7'b0100000,
    S_OUT = 7'b1000000
  } state_t;
  state_t state;

  cfg_t cfg;
  logic signed [47:0] drum_mem [DRUM_COUNT];
  logic signed [15:0] tip [2][3];
  logic [15:0] dus;
  logic [30:0] step_q;
  logic ld;
  logic [2:0] sel_q;
  logic arm;
  logic [DW:0] didx;
  logic signed [47:0] drum_rd;
  logic signed [15:0] prev_z [2];
  logic signed [23:0] vel [2];
  logic seeded;
  logic [DRUM_COUNT-1:0] armed [2];
  logic [DRUM_COUNT-1:0] prior_mask;
  logic signed [31:0] last_hit [2];
  logic tch [2];
  logic [DW-1:0] near [2];
  logic hit [2];
  logic [32:0] best;
  logic signed [23:0] raw;
  logic signed [41:0] prod;
  logic signed [41:0] acc;
  logic mul_ph;
  logic dstart;
  div_req_t dreq;
  div_rsp_t drsp;

  sthd_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign pready = 1'b1;
  always_comb begin
    case (paddr[4:2])
      REG_ALPHA: prdata = {15'd0, cfg.alpha};
      REG_RADIUS: prdata = {17'd0, cfg.radius};
      REG_ZWIN: prdata = {17'd0, cfg.zwin};
      REG_REARM: prdata = {17'd0, cfg.rearm};
      REG_MINSPD: prdata = {9'd0, cfg.minspd};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{alpha: 17'd32768, radius: 15'd500, zwin: 15'd300, rearm: 15'd500,
               minspd: 23'd0};
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_ALPHA: cfg.alpha <= pwdata[16:0];
        REG_RADIUS: cfg.radius <= pwdata[14:0];
        REG_ZWIN: cfg.zwin <= pwdata[14:0];
        REG_REARM: cfg.rearm <= pwdata[14:0];
        REG_MINSPD: cfg.minspd <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // Shared distance unit for the drum scan.
  logic signed [16:0] dx, dy, dz;
  logic [33:0] dxy2;
  logic [33:0] d2;
  logic signed [15:0] tx, ty, tz;
  assign tx = tip[arm][0];
  assign ty = tip[arm][1];
  assign tz = tip[arm][2];
  assign dx = 17'(tx) - 17'($signed(drum_rd[47:32]));
  assign dy = 17'(ty) - 17'($signed(drum_rd[31:16]));
  assign dz = 17'(tz) - 17'($signed(drum_rd[15:0]));
  assign dxy2 = 34'(dx * dx) + 34'(dy * dy);
  assign d2 = dxy2 + 34'(dz * dz);
  logic in_r, contact, rearm_hit;
  assign in_r = dxy2 <= 34'(cfg.radius * cfg.radius);
  assign contact = in_r && !dz[16] && (dz <= $signed({2'b0, cfg.zwin}));
  assign rearm_hit = dz > $signed({2'b0, cfg.rearm});

  logic [16:0] a_sat;
  assign a_sat = cfg.alpha[16] ? 17'd65536 : cfg.alpha;
  logic signed [16:0] dzv;
  assign dzv = 17'(tz) - 17'(prev_z[arm]);

  always_ff @(posedge clk) begin
    if (ld && state == S_FIN && int'(sel_q) < DRUM_COUNT)
      drum_mem[DW'(sel_q)] <= {tip[0][0], tip[0][1], tip[0][2]};
    drum_rd <= drum_mem[didx[DW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seeded <= 1'b0;
      prev_z[0] <= '0; prev_z[1] <= '0;
      vel[0] <= '0; vel[1] <= '0;
      armed[0] <= '0; armed[1] <= '0;
      last_hit[0] <= NO_HIT_STEP; last_hit[1] <= NO_HIT_STEP;
      dstart <= 1'b0;
    end else begin
      dstart <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) begin
          tip[0][0] <= left_x; tip[0][1] <= left_y; tip[0][2] <= left_z;
          tip[1][0] <= right_x; tip[1][1] <= right_y; tip[1][2] <= right_z;
          dus <= delta_us; step_q <= step_now; ld <= !op; sel_q <= drum_sel;
          arm <= 1'b0;
          tch[0] <= 1'b0; tch[1] <= 1'b0; hit[0] <= 1'b0; hit[1] <= 1'b0;
          near[0] <= '0; near[1] <= '0;
          if (!op) state <= S_FIN;
          else if (!seeded || delta_us == 16'd0) state <= S_SCAN;
          else begin
            state <= S_DIV;
            dstart <= 1'b1;
          end
          didx <= '0;
          best <= '0;
        end
        S_DIV: if (drsp.done) begin
          raw <= drsp.quot;
          mul_ph <= 1'b0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (!mul_ph) prod <= $signed({1'b0, a_sat}) * raw;
          else prod <= $signed({1'b0, 17'd65536 - a_sat}) * vel[arm];
          state <= S_ACC;
        end
        S_ACC: begin
          if (!mul_ph) begin
            acc <= prod;
            mul_ph <= 1'b1;
            state <= S_MUL;
          end else begin
            vel[arm] <= VW'((acc + prod + 42'sd32768) >>> 16);
            prev_z[arm] <= tz;
            if (!arm) begin
              arm <= 1'b1;
              state <= S_DIV;
              dstart <= 1'b1;
            end else begin
              arm <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!seeded) begin
            prev_z[0] <= tip[0][2]; prev_z[1] <= tip[1][2];
            seeded <= 1'b1;
          end
          if (didx == '0) prior_mask <= armed[arm];
          // drum_rd is registered, so it holds the drum of the previous address
          if (didx != '0) begin
            if (rearm_hit) armed[arm][didx[DW-1:0] - DW'(1)] <= 1'b1;
            if (contact && (!tch[arm] || 33'(d2) < best)) begin
              best <= 33'(d2);
              near[arm] <= didx[DW-1:0] - DW'(1);
              tch[arm] <= 1'b1;
            end
          end
          if (didx == (DW+1)'(DRUM_COUNT)) begin
            didx <= '0;
            state <= S_FIN;
          end else didx <= didx + 1'b1;
        end
        S_FIN: begin
          if (!ld) begin
            if (tch[arm]) begin
              armed[arm] <= '0;
              if (prior_mask[near[arm]] &&
                  ($signed({vel[arm][23], vel[arm]}) < -$signed({2'b0, cfg.minspd}))) begin
                last_hit[arm] <= {1'b0, step_q};
                hit[arm] <= 1'b1;
              end
            end
            if (!arm) begin
              arm <= 1'b1;
              best <= '0;
              state <= S_SCAN;
            end else state <= S_OUT;
          end else state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    dreq.start = dstart;
    dreq.divisor = dus;
    dreq.dividend = 37'(dzv) * 37'sd1000000;
  end

  assign armed_left = 8'(armed[0]);
  assign armed_right = 8'(armed[1]);
  assign touch_left = tch[0];
  assign touch_right = tch[1];
  assign touch_left_drum = 3'(near[0]);
  assign touch_right_drum = 3'(near[1]);
  assign hit_left = hit[0];
  assign hit_right = hit[1];
  assign last_hit_left = last_hit[0];
  assign last_hit_right = last_hit[1];
  assign vel_z_left = vel[0];
  assign vel_z_right = vel[1];
endmodule
`default_nettype wire

>>> sv/sthd_div.sv
`timescale 1ns / 1ps
`default_nettype none
module sthd_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sthd_pkg::div_req_t req,
  output sthd_pkg::div_rsp_t    rsp
);
  import sthd_pkg::*;
  logic [36:0] rem_q;
  logic [36:0] mag;
  logic [15:0] dvs;
  logic neg;
  logic [5:0] cnt;
  logic busy;
  logic done_q;
  logic [37:0] trial;
  logic [36:0] qsat;

  assign trial = {rem_q[36:0], mag[36]} - {22'd0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        neg <= req.dividend[36];
        mag <= req.dividend[36] ? 37'(-req.dividend) : 37'(req.dividend);
        dvs <= req.divisor;
        rem_q <= '0;
        cnt <= 6'd37;
      end else if (busy) begin
        if (!trial[37]) begin
          rem_q <= trial[36:0];
          mag <= {mag[35:0], 1'b1};
        end else begin
          rem_q <= {rem_q[35:0], mag[36]};
          mag <= {mag[35:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done_q;
    qsat = mag;
    if (neg) begin
      if (qsat > 37'd8388608) rsp.quot = -24'sd8388608;
      else rsp.quot = VW'(-qsat);
    end else begin
      if (qsat > 37'd8388607) rsp.quot = 24'sd8388607;
      else rsp.quot = VW'(qsat);
    end
  end
endmodule
`default_nettype wire

>>> sv/sthd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "stick_tip_hit_detector_core_assert.svh"
module sthd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic hit_left,
  input wire logic touch_left,
  input wire logic [7:0] armed_left
);
  `STHD_ASSERT_IMPL(a_excl, out_valid, !in_ready)
  `STHD_ASSERT_IMPL(a_hit_touch, out_valid && hit_left, touch_left)
  `STHD_ASSERT_IMPL(a_touch_disarm, out_valid && touch_left, armed_left == 8'd0)
  `STHD_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)
endmodule
bind stick_tip_hit_detector_core sthd_checker u_chk (.*);
`default_nettype wire
